// File: hdl/cda_pkg.sv
package cda_pkg;

    // serial day accumulator, wide enough for any year, offset and difference
    localparam int SW = 27;
    // year counter of the date walk, holds MAX_YEAR
    localparam int YW = 16;
    // remaining-year counter of the serial walk, holds year + 399
    localparam int RW = 15;
    // width of the day difference result
    localparam int DW = 23;

    typedef logic signed [SW-1:0] t_serial;

    localparam t_serial DAYS_400Y = t_serial'(146097);
    localparam t_serial DAYS_100Y = t_serial'(36524);
    localparam t_serial DAYS_4Y   = t_serial'(1461);
    localparam t_serial DAYS_1Y   = t_serial'(365);
    localparam t_serial DIFF_MAX  = t_serial'(4194303);
    localparam t_serial DIFF_MIN  = -t_serial'(4194304);

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_SUB  = 2'd1;
    localparam logic [1:0] MODE_DIFF = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SER_INIT,
        OP_Y400,
        OP_Y100,
        OP_Y4,
        OP_Y1,
        OP_MADD,
        OP_DAY,
        OP_DAY_SAVE,
        OP_ADD_OFS,
        OP_SUB_OFS,
        OP_CLAMP,
        OP_D400,
        OP_D100,
        OP_D4,
        OP_D1,
        OP_DMON,
        OP_DIFF,
        OP_RES_DATE,
        OP_RES_DIFF,
        OP_RES_ZERO
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_other;
    } t_cmd;

    typedef struct packed {
        logic y400;
        logic y100;
        logic y4;
        logic y1;
        logic mon_more;
        logic d400;
        logic d100;
        logic d4;
        logic d1;
        logic dmon_more;
    } t_status;

    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2: begin
                len = 5'd28 + {4'd0, leap};
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

// File: hdl/cda_ctrl.sv
module cda_ctrl
    import cda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    input  logic       i_out_stall,
    input  t_status    i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_Y400,
        S_Y100,
        S_Y4,
        S_Y1,
        S_MON,
        S_DAY,
        S_OFS,
        S_CLAMP,
        S_D400,
        S_D100,
        S_D4,
        S_D1,
        S_DMON,
        S_DIFF,
        S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic       r_pass, n_pass;
    logic [1:0] r_mode, n_mode;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state       = r_state;
        n_pass        = r_pass;
        n_mode        = r_mode;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.op        = OP_NONE;
        o_cmd.sel_other = (r_mode == MODE_DIFF) && !r_pass;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_mode   = i_mode;
                    n_pass   = 1'b0;
                    n_state  = (i_mode == MODE_NONE) ? S_DONE : S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.op = OP_SER_INIT;
                n_state  = S_Y400;
            end
            S_Y400: begin
                if (i_status.y400) o_cmd.op = OP_Y400;
                else n_state = S_Y100;
            end
            S_Y100: begin
                if (i_status.y100) o_cmd.op = OP_Y100;
                else n_state = S_Y4;
            end
            S_Y4: begin
                if (i_status.y4) o_cmd.op = OP_Y4;
                else n_state = S_Y1;
            end
            S_Y1: begin
                if (i_status.y1) o_cmd.op = OP_Y1;
                else n_state = S_MON;
            end
            S_MON: begin
                if (i_status.mon_more) o_cmd.op = OP_MADD;
                else n_state = S_DAY;
            end
            S_DAY: begin
                if (r_mode == MODE_DIFF && !r_pass) begin
                    o_cmd.op = OP_DAY_SAVE;
                    n_pass   = 1'b1;
                    n_state  = S_INIT;
                end else if (r_mode == MODE_DIFF) begin
                    o_cmd.op = OP_DAY;
                    n_state  = S_DIFF;
                end else begin
                    o_cmd.op = OP_DAY;
                    n_state  = S_OFS;
                end
            end
            S_OFS: begin
                o_cmd.op = (r_mode == MODE_SUB) ? OP_SUB_OFS : OP_ADD_OFS;
                n_state  = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = S_D400;
            end
            S_D400: begin
                if (i_status.d400) o_cmd.op = OP_D400;
                else n_state = S_D100;
            end
            S_D100: begin
                if (i_status.d100) o_cmd.op = OP_D100;
                else n_state = S_D4;
            end
            S_D4: begin
                if (i_status.d4) o_cmd.op = OP_D4;
                else n_state = S_D1;
            end
            S_D1: begin
                if (i_status.d1) o_cmd.op = OP_D1;
                else n_state = S_DMON;
            end
            S_DMON: begin
                if (i_status.dmon_more) o_cmd.op = OP_DMON;
                else n_state = S_DONE;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (r_mode == MODE_ADD || r_mode == MODE_SUB) o_cmd.op = OP_RES_DATE;
                    else if (r_mode == MODE_DIFF) o_cmd.op = OP_RES_DIFF;
                    else o_cmd.op = OP_RES_ZERO;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= 1'b0;
            r_mode      <= MODE_ADD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/cda_dp.sv
module cda_dp
    import cda_pkg::*;
#(
    parameter int MAX_YEAR    = 9999,
    parameter int OFFSET_BITS = 20
)
(
    input  logic                   i_clk,
    input  t_cmd                   i_cmd,
    input  logic [13:0]            i_year,
    input  logic [3:0]             i_month,
    input  logic [4:0]             i_day,
    input  logic [OFFSET_BITS-1:0] i_day_offset,
    input  logic [13:0]            i_other_year,
    input  logic [3:0]             i_other_month,
    input  logic [4:0]             i_other_day,
    output t_status                o_status,
    output logic [13:0]            o_result_year,
    output logic [3:0]             o_result_month,
    output logic [4:0]             o_result_day,
    output logic signed [DW-1:0]   o_day_difference,
    output logic                   o_out_of_range
);

    // serial number of MAX_YEAR-12-31
    localparam int      LAST_DAY = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                   + MAX_YEAR / 400 - 1;
    localparam t_serial LAST_S   = t_serial'(LAST_DAY);

    // captured request
    logic [13:0]            r_year, r_oyear;
    logic [3:0]             r_month, r_omonth;
    logic [4:0]             r_day, r_oday;
    logic [OFFSET_BITS-1:0] r_offset;

    // working registers
    t_serial          r_acc, r_save;
    logic [RW-1:0]    r_rem;
    logic [YW-1:0]    r_yy;
    logic [1:0]       r_b;
    logic [4:0]       r_c;
    logic [1:0]       r_d;
    logic [3:0]       r_mon, r_mlim;
    logic [4:0]       r_dsel;
    logic             r_flag;

    // result register
    logic [13:0]          r_res_year;
    logic [3:0]           r_res_month;
    logic [4:0]           r_res_day;
    logic signed [DW-1:0] r_res_diff;
    logic                 r_res_flag;

    logic [13:0] y_sel;
    logic [3:0]  m_sel, m_clamp;
    logic [4:0]  d_sel;
    logic        leap;
    logic [4:0]  mlen;
    t_serial     day_sum;

    assign y_sel   = i_cmd.sel_other ? r_oyear : r_year;
    assign m_sel   = i_cmd.sel_other ? r_omonth : r_month;
    assign d_sel   = i_cmd.sel_other ? r_oday : r_day;
    assign m_clamp = (m_sel == 4'd0) ? 4'd1 : ((m_sel > 4'd12) ? 4'd12 : m_sel);

    // year position within its 400-year cycle tells leap: last of a
    // 4-year group, unless it closes a century other than the fourth
    assign leap    = (r_d == 2'd3) && ((r_c != 5'd24) || (r_b == 2'd3));
    assign mlen    = f_month_len(r_mon, leap);
    assign day_sum = r_acc + t_serial'(r_dsel) - t_serial'(1);

    always_comb begin
        o_status.y400      = r_rem >= RW'(400);
        o_status.y100      = r_rem >= RW'(100);
        o_status.y4        = r_rem >= RW'(4);
        o_status.y1        = r_rem != '0;
        o_status.mon_more  = r_mon < r_mlim;
        o_status.d400      = r_acc >= DAYS_400Y;
        o_status.d100      = (r_acc >= DAYS_100Y) && (r_b != 2'd3);
        o_status.d4        = r_acc >= DAYS_4Y;
        o_status.d1        = (r_acc >= DAYS_1Y) && (r_d != 2'd3);
        o_status.dmon_more = (r_mon != 4'd12) && (r_acc >= t_serial'(mlen));
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_year   <= i_year;
                r_month  <= i_month;
                r_day    <= i_day;
                r_offset <= i_day_offset;
                r_oyear  <= i_other_year;
                r_omonth <= i_other_month;
                r_oday   <= i_other_day;
                r_flag   <= 1'b0;
            end
            OP_SER_INIT: begin
                // count from year + 399 so that year zero needs no special case
                r_acc  <= -DAYS_400Y;
                r_rem  <= RW'(y_sel) + RW'(399);
                r_b    <= '0;
                r_c    <= '0;
                r_d    <= '0;
                r_mon  <= 4'd1;
                r_mlim <= m_clamp;
                r_dsel <= d_sel;
            end
            OP_Y400: begin
                r_rem <= r_rem - RW'(400);
                r_acc <= r_acc + DAYS_400Y;
            end
            OP_Y100: begin
                r_rem <= r_rem - RW'(100);
                r_acc <= r_acc + DAYS_100Y;
                r_b   <= r_b + 2'd1;
            end
            OP_Y4: begin
                r_rem <= r_rem - RW'(4);
                r_acc <= r_acc + DAYS_4Y;
                r_c   <= r_c + 5'd1;
            end
            OP_Y1: begin
                r_rem <= r_rem - RW'(1);
                r_acc <= r_acc + DAYS_1Y;
                r_d   <= r_d + 2'd1;
            end
            OP_MADD: begin
                r_acc <= r_acc + t_serial'(mlen);
                r_mon <= r_mon + 4'd1;
            end
            OP_DAY: begin
                r_acc <= day_sum;
            end
            OP_DAY_SAVE: begin
                r_save <= day_sum;
            end
            OP_ADD_OFS: begin
                r_acc <= r_acc + t_serial'(r_offset);
            end
            OP_SUB_OFS: begin
                r_acc <= r_acc - t_serial'(r_offset);
            end
            OP_CLAMP: begin
                if (r_acc[SW-1]) begin
                    r_acc  <= '0;
                    r_flag <= 1'b1;
                end else if (r_acc > LAST_S) begin
                    r_acc  <= LAST_S;
                    r_flag <= 1'b1;
                end
                r_yy  <= YW'(1);
                r_b   <= '0;
                r_c   <= '0;
                r_d   <= '0;
                r_mon <= 4'd1;
            end
            OP_D400: begin
                r_acc <= r_acc - DAYS_400Y;
                r_yy  <= r_yy + YW'(400);
            end
            OP_D100: begin
                r_acc <= r_acc - DAYS_100Y;
                r_yy  <= r_yy + YW'(100);
                r_b   <= r_b + 2'd1;
            end
            OP_D4: begin
                r_acc <= r_acc - DAYS_4Y;
                r_yy  <= r_yy + YW'(4);
                r_c   <= r_c + 5'd1;
            end
            OP_D1: begin
                r_acc <= r_acc - DAYS_1Y;
                r_yy  <= r_yy + YW'(1);
                r_d   <= r_d + 2'd1;
            end
            OP_DMON: begin
                r_acc <= r_acc - t_serial'(mlen);
                r_mon <= r_mon + 4'd1;
            end
            OP_DIFF: begin
                r_acc <= r_acc - r_save;
            end
            OP_RES_DATE: begin
                r_res_year  <= r_yy[13:0];
                r_res_month <= r_mon;
                r_res_day   <= r_acc[4:0] + 5'd1;
                r_res_diff  <= '0;
                r_res_flag  <= r_flag;
            end
            OP_RES_DIFF: begin
                r_res_year  <= '0;
                r_res_month <= '0;
                r_res_day   <= '0;
                if (r_acc > DIFF_MAX) begin
                    r_res_diff <= DIFF_MAX[DW-1:0];
                    r_res_flag <= 1'b1;
                end else if (r_acc < DIFF_MIN) begin
                    r_res_diff <= DIFF_MIN[DW-1:0];
                    r_res_flag <= 1'b1;
                end else begin
                    r_res_diff <= r_acc[DW-1:0];
                    r_res_flag <= 1'b0;
                end
            end
            OP_RES_ZERO: begin
                r_res_year  <= '0;
                r_res_month <= '0;
                r_res_day   <= '0;
                r_res_diff  <= '0;
                r_res_flag  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_result_year    = r_res_year;
    assign o_result_month   = r_res_month;
    assign o_result_day     = r_res_day;
    assign o_day_difference = r_res_diff;
    assign o_out_of_range   = r_res_flag;

endmodule

// File: hdl/calendar_date_arithmetic_unit.sv
// Gregorian date arithmetic (proleptic calendar, 0001-01-01 is serial day 0).
// mode 0 adds i_day_offset to the first date, mode 1 subtracts it, mode 2
// returns first date minus second date in days, mode 3 returns all zeros.
// out-of-range results saturate (to 0001-01-01, MAX_YEAR-12-31, or the 23-bit
// difference limits) and raise o_out_of_range. a month of 0 reads as 1 and
// above 12 as 12; an overlong day rolls into the following month. one request
// is in work at a time. the shared accumulator in the datapath walks one step
// per cycle - 400-year blocks, centuries, 4-year groups, years and then
// months, once to turn each date into a serial day and, in modes 0 and 1,
// once more to turn the sum back into a date. a finished result sits in
// the output register, so the next request is taken while it waits; a result
// that finds the previous one still stalled waits for it to be taken.
module calendar_date_arithmetic_unit
    import cda_pkg::*;
#(
    parameter int MAX_YEAR    = 9999,
    parameter int OFFSET_BITS = 20
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_mode,
    input  logic [13:0]            i_year,
    input  logic [3:0]             i_month,
    input  logic [4:0]             i_day,
    input  logic [OFFSET_BITS-1:0] i_day_offset,
    input  logic [13:0]            i_other_year,
    input  logic [3:0]             i_other_month,
    input  logic [4:0]             i_other_day,

    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [13:0]            o_result_year,
    output logic [3:0]             o_result_month,
    output logic [4:0]             o_result_day,
    output logic signed [DW-1:0]   o_day_difference,
    output logic                   o_out_of_range
);

    t_cmd    cmd;
    t_status status;

    // sequencer: owns the handshakes and steps the walk
    cda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // accumulator, counters and result register
    cda_dp #(
        .MAX_YEAR    (MAX_YEAR),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_year           (i_year),
        .i_month          (i_month),
        .i_day            (i_day),
        .i_day_offset     (i_day_offset),
        .i_other_year     (i_other_year),
        .i_other_month    (i_other_month),
        .i_other_day      (i_other_day),
        .o_status         (status),
        .o_result_year    (o_result_year),
        .o_result_month   (o_result_month),
        .o_result_day     (o_result_day),
        .o_day_difference (o_day_difference),
        .o_out_of_range   (o_out_of_range)
    );

endmodule

// File: hdl/cda_checker.sv
module cda_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [13:0]        o_result_year,
    input logic [3:0]         o_result_month,
    input logic [4:0]         o_result_day,
    input logic signed [22:0] o_day_difference,
    input logic               o_out_of_range
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_result_year) && $stable(o_result_month)
            && $stable(o_result_day) && $stable(o_day_difference)
            && $stable(o_out_of_range))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a date result never carries a difference
    a_date_no_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_month != 4'd0 |-> o_day_difference == 23'sd0)
        else $error("date result with nonzero difference");

    // a date result has a nonzero day and a month of at most 12
    a_date_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_month != 4'd0 |->
            o_result_day != 5'd0 && o_result_month <= 4'd12)
        else $error("malformed result date");

endmodule

bind calendar_date_arithmetic_unit cda_checker u_cda_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_result_year    (o_result_year),
    .o_result_month   (o_result_month),
    .o_result_day     (o_result_day),
    .o_day_difference (o_day_difference),
    .o_out_of_range   (o_out_of_range)
);
